[hdl/tap_hold_double_tap_key_reporter_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the key reporter
// Overlapping and next-cycle implication checks, held off during reset.
// ----------------------------------------------------------------------------
`ifndef TAP_HOLD_DOUBLE_TAP_KEY_REPORTER_UNIT_MACROS_SVH
`define TAP_HOLD_DOUBLE_TAP_KEY_REPORTER_UNIT_MACROS_SVH

// same-cycle implication
`define THKR_ASSERT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("key reporter check failed");

// next-cycle implication
`define THKR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("key reporter check failed");

`endif

[hdl/thkr_pkg.sv]
// ----------------------------------------------------------------------------
// thkr_pkg
// Types and codes shared by the key reporter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package thkr_pkg;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0]  CFG_HOLD_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_TAP_WINDOW   = 1'd1;
  localparam logic [CFG_DATA_W-1:0] CFG_RESET_VALUE  = 16'd200;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_KEY   = 2'd1;
  localparam logic [1:0] OP_LAYER = 2'd2;

  localparam logic [1:0] KIND_OVERLAY = 2'd0;
  localparam logic [1:0] KIND_TAP     = 2'd1;
  localparam logic [1:0] KIND_HOLD    = 2'd2;

  localparam logic [1:0] EDGE_PRESS   = 2'd1;
  localparam logic [1:0] EDGE_RELEASE = 2'd2;

  localparam logic [1:0] PK_LAYER   = 2'd0;
  localparam logic [1:0] PK_OVERLAY = 2'd1;
  localparam logic [1:0] PK_TAP     = 2'd2;
  localparam logic [1:0] PK_HOLD    = 2'd3;

  localparam logic [7:0] EV_TAP     = 8'd0;
  localparam logic [7:0] EV_DOUBLE  = 8'd1;
  localparam logic [7:0] EV_HOLD    = 8'd2;
  localparam logic [7:0] EV_RELEASE = 8'd3;

  typedef enum logic [4:0] {
    ST_IDLE           = 5'b00001,
    ST_PRESSED        = 5'b00010,
    ST_FIRST_UP       = 5'b00100,
    ST_HOLD_ACTIVE    = 5'b01000,
    ST_DOUBLE_PRESSED = 5'b10000
  } gesture_state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       host_link_up;
    logic [1:0] key_kind;
    logic [1:0] key_edge;
    logic [7:0] layer_value;
  } item_t;

  typedef struct packed {
    logic       packet_valid;
    logic [1:0] packet_kind;
    logic [7:0] packet_payload;
    logic       key_consumed;
    logic       last_result;
  } report_t;

  typedef struct packed {
    logic    two;
    report_t r0;
    report_t r1;
  } result_pair_t;

endpackage

`default_nettype wire

[hdl/thkr_if.sv]
// ----------------------------------------------------------------------------
// thkr_if
// Item, result and configuration channels of the key reporter.
// ----------------------------------------------------------------------------
`default_nettype none

interface thkr_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic       host_link_up;
  logic [1:0] key_kind;
  logic [1:0] key_edge;
  logic [7:0] layer_value;

  modport source (output valid, opcode, host_link_up, key_kind, key_edge, layer_value,
                  input ready);
  modport sink (input valid, opcode, host_link_up, key_kind, key_edge, layer_value,
                output ready);
endinterface

interface thkr_result_if;
  logic       valid;
  logic       ready;
  logic       packet_valid;
  logic [1:0] packet_kind;
  logic [7:0] packet_payload;
  logic       key_consumed;
  logic       last_result;

  modport source (output valid, packet_valid, packet_kind, packet_payload, key_consumed,
                  last_result, input ready);
  modport sink (input valid, packet_valid, packet_kind, packet_payload, key_consumed,
                last_result, output ready);
endinterface

interface thkr_cfg_if;
  import thkr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/thkr_gesture.sv]
// ----------------------------------------------------------------------------
// thkr_gesture
// Gesture machine, timers and layer state; forms the results of one item.
// ----------------------------------------------------------------------------
`default_nettype none

module thkr_gesture #(
  parameter int TIMER_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  thkr_pkg::item_t                 item,
  input  logic                            commit,
  input  logic [thkr_pkg::CFG_DATA_W-1:0] hold_timeout_ms,
  input  logic [thkr_pkg::CFG_DATA_W-1:0] tap_window_ms,
  output thkr_pkg::result_pair_t          pair
);
  import thkr_pkg::*;

  gesture_state_t        state, state_next;
  logic [TIMER_BITS-1:0] hold_count, hold_count_next;
  logic [TIMER_BITS-1:0] tap_count, tap_count_next;
  logic [7:0]            current_layer, current_layer_next;
  logic                  initial_sent, initial_sent_next;

  logic [TIMER_BITS-1:0] hold_load, tap_load;
  logic                  fire, consumed;
  logic [7:0]            gesture_ev;
  logic                  a_v, b_v;
  logic [1:0]            a_kind, b_kind;
  logic [7:0]            a_pay, b_pay;

  // saturate the timeout registers to the timer width
  if (TIMER_BITS >= CFG_DATA_W) begin : g_wide
    assign hold_load = TIMER_BITS'(hold_timeout_ms);
    assign tap_load  = TIMER_BITS'(tap_window_ms);
  end else begin : g_narrow
    assign hold_load = (|hold_timeout_ms[CFG_DATA_W-1:TIMER_BITS]) ? '1
                     : hold_timeout_ms[TIMER_BITS-1:0];
    assign tap_load  = (|tap_window_ms[CFG_DATA_W-1:TIMER_BITS]) ? '1
                     : tap_window_ms[TIMER_BITS-1:0];
  end

  always_comb begin
    state_next         = state;
    hold_count_next    = hold_count;
    tap_count_next     = tap_count;
    current_layer_next = current_layer;
    initial_sent_next  = initial_sent;
    fire       = 1'b0;
    gesture_ev = EV_TAP;
    consumed   = 1'b0;
    a_v    = 1'b0;
    a_kind = PK_LAYER;
    a_pay  = 8'd0;
    b_v    = 1'b0;
    b_kind = PK_LAYER;
    b_pay  = 8'd0;

    case (item.opcode)
      OP_TICK: begin
        if (!initial_sent && item.host_link_up) begin
          initial_sent_next = 1'b1;
          a_v   = 1'b1;
          a_pay = current_layer;
        end
        unique case (state)
          ST_PRESSED: begin
            if (hold_count[TIMER_BITS-1:1] == '0) begin
              hold_count_next = '0;
              state_next      = ST_HOLD_ACTIVE;
              fire            = 1'b1;
              gesture_ev      = EV_HOLD;
            end else begin
              hold_count_next = hold_count - 1'b1;
            end
          end
          ST_FIRST_UP: begin
            if (tap_count[TIMER_BITS-1:1] == '0) begin
              tap_count_next = '0;
              state_next     = ST_IDLE;
              fire           = 1'b1;
              gesture_ev     = EV_TAP;
            end else begin
              tap_count_next = tap_count - 1'b1;
            end
          end
          default: ;
        endcase
        // the layer packet goes first when both come on one tick
        if (fire) begin
          if (a_v) begin
            b_v    = 1'b1;
            b_kind = PK_OVERLAY;
            b_pay  = gesture_ev;
          end else begin
            a_v    = 1'b1;
            a_kind = PK_OVERLAY;
            a_pay  = gesture_ev;
          end
        end
      end
      OP_KEY: begin
        case (item.key_kind) inside
          KIND_OVERLAY: begin
            consumed = 1'b1;
            case (item.key_edge)
              EDGE_PRESS: begin
                if (state == ST_IDLE) begin
                  state_next      = ST_PRESSED;
                  hold_count_next = hold_load;
                end else if (state == ST_FIRST_UP) begin
                  state_next = ST_DOUBLE_PRESSED;
                  a_v    = 1'b1;
                  a_kind = PK_OVERLAY;
                  a_pay  = EV_DOUBLE;
                end
              end
              EDGE_RELEASE: begin
                if (state == ST_PRESSED) begin
                  state_next     = ST_FIRST_UP;
                  tap_count_next = tap_load;
                end else if (state == ST_HOLD_ACTIVE || state == ST_DOUBLE_PRESSED) begin
                  state_next = ST_IDLE;
                  a_v    = 1'b1;
                  a_kind = PK_OVERLAY;
                  a_pay  = EV_RELEASE;
                end
              end
              default: ;
            endcase
          end
          KIND_TAP, KIND_HOLD: begin
            consumed = 1'b1;
            a_kind   = (item.key_kind == KIND_TAP) ? PK_TAP : PK_HOLD;
            case (item.key_edge)
              EDGE_PRESS: begin
                a_v   = 1'b1;
                a_pay = (item.key_kind == KIND_TAP) ? EV_TAP : EV_HOLD;
              end
              EDGE_RELEASE: begin
                a_v   = 1'b1;
                a_pay = EV_RELEASE;
              end
              default: ;
            endcase
            if (!a_v) a_kind = PK_LAYER;
          end
          default: ;
        endcase
      end
      OP_LAYER: begin
        current_layer_next = item.layer_value;
        a_v   = 1'b1;
        a_pay = item.layer_value;
      end
      default: ;
    endcase

    pair.two               = b_v;
    pair.r0.packet_valid   = a_v;
    pair.r0.packet_kind    = a_kind;
    pair.r0.packet_payload = a_pay;
    pair.r0.key_consumed   = consumed;
    pair.r0.last_result    = !b_v;
    pair.r1.packet_valid   = b_v;
    pair.r1.packet_kind    = b_kind;
    pair.r1.packet_payload = b_pay;
    pair.r1.key_consumed   = consumed;
    pair.r1.last_result    = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      hold_count    <= '0;
      tap_count     <= '0;
      current_layer <= 8'd0;
      initial_sent  <= 1'b0;
    end else if (commit) begin
      state         <= state_next;
      hold_count    <= hold_count_next;
      tap_count     <= tap_count_next;
      current_layer <= current_layer_next;
      initial_sent  <= initial_sent_next;
    end
  end

endmodule

`default_nettype wire

[hdl/thkr_out_buf.sv]
// ----------------------------------------------------------------------------
// thkr_out_buf
// Two-slot result register; presents one result at a time to the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module thkr_out_buf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  thkr_pkg::result_pair_t pair,
  output logic                   room,
  thkr_result_if.source          result
);
  import thkr_pkg::*;

  logic [1:0] count;
  report_t    slot0, slot1;
  logic       pop;

  assign pop  = result.valid && result.ready;
  assign room = (count == 2'd0) || (count == 2'd1 && result.ready);

  assign result.valid          = (count != 2'd0);
  assign result.packet_valid   = slot0.packet_valid;
  assign result.packet_kind    = slot0.packet_kind;
  assign result.packet_payload = slot0.packet_payload;
  assign result.key_consumed   = slot0.key_consumed;
  assign result.last_result    = slot0.last_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= pair.two ? 2'd2 : 2'd1;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  // advance the second result into the front slot on a pop
  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= pair.r0;
      slot1 <= pair.r1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

`default_nettype wire

[hdl/tap_hold_double_tap_key_reporter_unit.sv]
// Path: an accepted item is held in the input register, and its results are
// then loaded into the result register, which offers them to the sink.
// Throughput: one item per cycle while the result buffer has room; an item
// with two results holds the single result port of the output register for both.
// Reset (rst, synchronous): gesture idle, timers and layer zero, no initial
// layer sent, both timeout registers 200, input and output stages empty.
// ----------------------------------------------------------------------------
// tap_hold_double_tap_key_reporter_unit
// Top level: input register, configuration registers, gesture core and
// result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module tap_hold_double_tap_key_reporter_unit #(
  parameter int TIMER_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  thkr_item_if.sink     item,
  thkr_result_if.source result,
  thkr_cfg_if.sink      cfg
);
  import thkr_pkg::*;

  item_t                 item_q;
  logic                  item_vld;
  logic                  room, commit;
  logic [CFG_DATA_W-1:0] hold_timeout_ms, tap_window_ms;
  result_pair_t          pair;

  assign commit     = item_vld && room;
  assign item.ready = !item_vld || commit;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (item.valid && item.ready) begin
      item_vld <= 1'b1;
    end else if (commit) begin
      item_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      item_q.opcode       <= item.opcode;
      item_q.host_link_up <= item.host_link_up;
      item_q.key_kind     <= item.key_kind;
      item_q.key_edge     <= item.key_edge;
      item_q.layer_value  <= item.layer_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_timeout_ms <= CFG_RESET_VALUE;
      tap_window_ms   <= CFG_RESET_VALUE;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_HOLD_TIMEOUT: hold_timeout_ms <= cfg.data;
        CFG_TAP_WINDOW:   tap_window_ms   <= cfg.data;
        default: ;
      endcase
    end
  end

  thkr_gesture #(
    .TIMER_BITS (TIMER_BITS)
  ) u_gesture (
    .clk             (clk),
    .rst             (rst),
    .item            (item_q),
    .commit          (commit),
    .hold_timeout_ms (hold_timeout_ms),
    .tap_window_ms   (tap_window_ms),
    .pair            (pair)
  );

  thkr_out_buf u_out_buf (
    .clk    (clk),
    .rst    (rst),
    .load   (commit),
    .pair   (pair),
    .room   (room),
    .result (result)
  );

endmodule

`default_nettype wire

[hdl/thkr_checker.sv]
// ----------------------------------------------------------------------------
// thkr_checker
// Port-level checks on the result channel of the key reporter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tap_hold_double_tap_key_reporter_unit_macros.svh"

module thkr_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_ready,
  input logic       packet_valid,
  input logic [1:0] packet_kind,
  input logic [7:0] packet_payload,
  input logic       key_consumed,
  input logic       last_result
);
  import thkr_pkg::*;

  `THKR_ASSERT_NXT(a_stall_hold, clk, rst, result_valid && !result_ready,
    result_valid && $stable(packet_kind) && $stable(packet_payload) && $stable(last_result))

  `THKR_ASSERT(a_empty_fields, clk, rst, result_valid && !packet_valid,
    packet_kind == PK_LAYER && packet_payload == 8'd0 && last_result)

  `THKR_ASSERT(a_layer_free, clk, rst, result_valid && packet_valid && packet_kind == PK_LAYER,
    !key_consumed)

  // the second result of a pair follows at once and closes the item
  `THKR_ASSERT_NXT(a_second, clk, rst, result_valid && result_ready && !last_result,
    result_valid && packet_valid && last_result)

endmodule

bind tap_hold_double_tap_key_reporter_unit thkr_checker u_thkr_checker (
  .clk            (clk),
  .rst            (rst),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .packet_valid   (result.packet_valid),
  .packet_kind    (result.packet_kind),
  .packet_payload (result.packet_payload),
  .key_consumed   (result.key_consumed),
  .last_result    (result.last_result)
);

`default_nettype wire
